@@ sv/symbol_quote_table_with_history_core_defines.svh @@
// ----------------------------------------------------------------------------
// Quote table assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_QUOTE_TABLE_WITH_HISTORY_CORE_DEFINES_SVH
`define SYMBOL_QUOTE_TABLE_WITH_HISTORY_CORE_DEFINES_SVH

// Same-cycle implication.
`define SQT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quote table assertion failed");

// Next-cycle implication.
`define SQT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quote table assertion failed");

`endif

@@ sv/sqt_pkg.sv @@
// ----------------------------------------------------------------------------
// Quote table package
// Sizes, payload layouts, control types and key normalization.
// ----------------------------------------------------------------------------
`default_nettype none

package sqt_pkg;

  localparam int MAX_SLOTS     = 64;
  localparam int HISTORY_DEPTH = 64;
  localparam int SYMBOL_CHARS  = 8;

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int HEAD_W = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  localparam int KEY_W      = 64;
  localparam int PRICE_W    = 48;
  localparam int VOL_W      = 40;
  localparam int TS_W       = 63;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int FILL_OUT_W = 7;

  localparam int IN_BITS     = KEY_W + 3 * PRICE_W + VOL_W + TS_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_W + SLOT_OUT_W + FILL_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED = 2'd0,
    ST_ADDED   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic [TS_W-1:0]    time_stamp;
    logic [VOL_W-1:0]   traded_volume;
    logic [PRICE_W-1:0] ask_price;
    logic [PRICE_W-1:0] bid_price;
    logic [PRICE_W-1:0] last_price;
  } quote_t;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [FILL_W-1:0] fill;
  } ring_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_ENC  = 4'b0100,
    S_UPD  = 4'b1000
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic look;
    logic enc;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // Keep the leading SYMBOL_CHARS characters; zero everything from the
  // first zero byte on, like a terminated string.
  function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] res;
    logic             live;
    logic [7:0]       ch;
    res  = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      ch = key[KEY_W-1-8*i -: 8];
      if (i >= SYMBOL_CHARS || ch == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        res[KEY_W-1-8*i -: 8] = ch;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/symbol_quote_table_with_history_core.sv @@
// ----------------------------------------------------------------------------
// Symbol quote table with per-slot price history
// Keeps the latest quote and a ring of recent prices for each symbol.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one quote update per transaction (key, prices, volume, timestamp).
//   out_* : one result per accepted update: status, slot index and the number
//           of prices held in that slot's history after the update.
//   A key is looked up among the slots in use; an unknown key takes the next
//   free slot with an empty history, and an update is dropped with status
//   "dropped" once every slot is taken.
//   An update is taken only once the last one has committed. Its steps are
//   capture, parallel key compare over all slot key registers, match encode
//   with the ring state memory read, then the update write into the slot
//   memories, with the result registered at the commit.
//   Reset empties the table (no slots in use) and drops any pending result.
//   When the receiver stalls, the result waits in the output register and the
//   next update is still taken and worked up to its commit, where it holds
//   until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_quote_table_with_history_core (
  input  wire                              clk,
  input  wire                              rst_n,
  // in_tdata, low bit up: symbol_key[63:0], last_price[47:0], bid_price[47:0],
  // ask_price[47:0], traded_volume[39:0], time_stamp[62:0], one zero pad bit
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [sqt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata, low bit up: status[1:0], slot[5:0], history_fill[6:0],
  // one zero pad bit
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [sqt_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sqt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence each transaction through lookup and commit
  sqt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // hold the table, the histories and the result register
  sqt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

@@ sv/sqt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Quote table controller
// Sequences capture, lookup, encode and commit for one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_tvalid,
  output logic          in_tready,
  output sqt_pkg::cmd_t cmd,
  input  sqt_pkg::sts_t sts
);
  import sqt_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.look    = (state_r == S_LOOK);
  assign cmd.enc     = (state_r == S_ENC);
  assign cmd.commit  = (state_r == S_UPD) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK:  state_nxt = S_ENC;
      S_ENC:   state_nxt = S_UPD;
      S_UPD: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/sqt_dpath.sv @@
// ----------------------------------------------------------------------------
// Quote table datapath
// Key registers with parallel compare, slot memories and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "symbol_quote_table_with_history_core_defines.svh"

module sqt_dpath (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  [sqt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  sqt_pkg::cmd_t                      cmd,
  output sqt_pkg::sts_t                      sts,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [sqt_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import sqt_pkg::*;

  // captured transaction
  logic [KEY_W-1:0]   key_r;
  quote_t             quote_r;

  // lookup results
  logic [MAX_SLOTS-1:0] match_r;
  logic                 found_r;
  logic                 full_r;
  logic [SLOT_W-1:0]    idx_r;
  ring_t                ring_rd_r;

  // table state
  logic [KEY_W-1:0]     slot_keys_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] quote_valid_r;
  logic [CNT_W-1:0]     slots_used_r;
  quote_t               quote_mem [MAX_SLOTS];
  logic [PRICE_W-1:0]   price_mem [MAX_SLOTS][HISTORY_DEPTH];
  ring_t                ring_mem  [MAX_SLOTS];

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [SLOT_W-1:0]            enc_idx;
  logic                         any_match;
  logic [HEAD_W-1:0]            head_cur;
  logic [FILL_W-1:0]            fill_cur;
  logic [HEAD_W-1:0]            head_new;
  logic [FILL_W-1:0]            fill_new;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [FILL_W+FILL_OUT_W-1:0] fill_ext;
  status_t                      status;
  logic                         do_write;

  // Keys are unique, so at most one match bit is set: OR the indexes.
  always_comb begin
    enc_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (match_r[i]) begin
        enc_idx = enc_idx | SLOT_W'(i);
      end
    end
  end
  assign any_match = |match_r;

  // A fresh slot starts with an empty ring.
  assign head_cur = found_r ? ring_rd_r.head : '0;
  assign fill_cur = found_r ? ring_rd_r.fill : '0;
  assign head_new = (head_cur == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_cur + 1'b1;
  assign fill_new = (fill_cur < FILL_W'(HISTORY_DEPTH)) ? fill_cur + 1'b1 : fill_cur;

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, idx_r};
  assign fill_ext = {{FILL_OUT_W{1'b0}}, fill_new};
  assign status   = full_r ? ST_DROPPED : (found_r ? ST_UPDATED : ST_ADDED);
  assign do_write = cmd.commit && !full_r;

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  // capture, compare and encode
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r                 <= normalize_key(in_tdata[KEY_W-1:0]);
      quote_r.last_price    <= in_tdata[KEY_W +: PRICE_W];
      quote_r.bid_price     <= in_tdata[KEY_W+PRICE_W +: PRICE_W];
      quote_r.ask_price     <= in_tdata[KEY_W+2*PRICE_W +: PRICE_W];
      quote_r.traded_volume <= in_tdata[KEY_W+3*PRICE_W +: VOL_W];
      quote_r.time_stamp    <= in_tdata[KEY_W+3*PRICE_W+VOL_W +: TS_W];
    end
    if (cmd.look) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        match_r[i] <= quote_valid_r[i] && (slot_keys_r[i] == key_r);
      end
    end
    if (cmd.enc) begin
      found_r   <= any_match;
      full_r    <= !any_match && (slots_used_r == CNT_W'(MAX_SLOTS));
      idx_r     <= any_match ? enc_idx : slots_used_r[SLOT_W-1:0];
      ring_rd_r <= ring_mem[enc_idx];
    end
    if (cmd.commit) begin
      // zero slot and fill on a drop, pad the top
      out_data_r <= {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                     full_r ? {FILL_OUT_W{1'b0}} : fill_ext[FILL_OUT_W-1:0],
                     full_r ? {SLOT_OUT_W{1'b0}} : slot_ext[SLOT_OUT_W-1:0],
                     status};
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (do_write) begin
      if (!found_r) begin
        slot_keys_r[idx_r] <= key_r;
      end
      quote_mem[idx_r]           <= quote_r;
      price_mem[idx_r][head_cur] <= quote_r.last_price;
      ring_mem[idx_r]            <= '{head: head_new, fill: fill_new};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r  <= '0;
      quote_valid_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (do_write && !found_r) begin
        slots_used_r <= slots_used_r + 1'b1;
      end
      if (do_write) begin
        quote_valid_r[idx_r] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `SQT_ASSERT_NOW(a_used_bound, 1'b1, slots_used_r <= CNT_W'(MAX_SLOTS))
  `SQT_ASSERT_NOW(a_unique_match, cmd.enc, $onehot0(match_r))
  `SQT_ASSERT_NEXT(a_add_counts, do_write && !found_r, slots_used_r == $past(slots_used_r) + 1'b1)
  `SQT_ASSERT_NOW(a_drop_when_full, cmd.commit && full_r, slots_used_r == CNT_W'(MAX_SLOTS))

endmodule

`default_nettype wire
